// ===== rtl/sset_pkg.sv =====
// ----------------------------------------------------------------------------
// sset_pkg
// shared types and constants for the two-set store
// ----------------------------------------------------------------------------
package sset_pkg;

  localparam int SetDepth = 16;
  localparam int IdxW = $clog2(SetDepth);
  localparam int CntW = $clog2(SetDepth + 1);
  localparam int QDepth = 2;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_INTER  = 3'd4,
    OP_UNION  = 3'd5,
    OP_DIFF   = 3'd6,
    OP_SYMD   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LEFT,
    S_RIGHT,
    S_TAIL
  } state_t;

  typedef struct packed {
    op_t         op;
    logic        sel;
    logic [31:0] value;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] member;
    logic        has_member;
    logic        last;
    logic [4:0]  set_count;
  } res_t;

endpackage

// ===== rtl/sset_front.sv =====
// ----------------------------------------------------------------------------
// sset_front
// input stage: unpacks beats and queues commands for the executor
// ----------------------------------------------------------------------------
module sset_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [39:0]       in_data,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output sset_pkg::cmd_t    cmd
);

  localparam int QW  = $clog2(sset_pkg::QDepth);
  localparam int QCW = $clog2(sset_pkg::QDepth + 1);

  sset_pkg::cmd_t q [sset_pkg::QDepth];
  logic [QW-1:0]  wp;
  logic [QW-1:0]  rp;
  logic [QCW-1:0] cnt;
  logic           push;
  logic           pop;

  assign in_ready  = (cnt != QCW'(sset_pkg::QDepth));
  assign cmd_valid = (cnt != '0);
  assign cmd       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{op: sset_pkg::op_t'(in_data[2:0]), sel: in_data[3],
                 value: in_data[35:4]};
    end
  end

  // queue depth is a power of two, pointers wrap naturally
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + QCW'(push) - QCW'(pop);
    end
  end

endmodule

// ===== rtl/sset_back.sv =====
// ----------------------------------------------------------------------------
// sset_back
// executor: holds both sets, runs table ops and streams set-op members
// ----------------------------------------------------------------------------
module sset_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  sset_pkg::cmd_t    cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output sset_pkg::res_t    res
);

  localparam int D = sset_pkg::SetDepth;
  localparam int IW = sset_pkg::IdxW;
  localparam int CW = sset_pkg::CntW;

  logic [31:0] ent [2][D];
  logic [CW-1:0] size [2];

  sset_pkg::state_t state, state_next;
  sset_pkg::cmd_t   cur;
  logic [CW-1:0]    idx;

  logic             a_s, b_s;
  logic [CW-1:0]    na, nb;
  logic [D-1:0]     hit_a, hit_b;
  logic             v_in_a;
  logic [IW-1:0]    hit_pos;
  logic [31:0]      elem;
  logic             elem_in_other;
  logic             scan_done;
  logic             want;
  logic             out_free;

  // command fields come from the queue head in idle, from the latch otherwise
  sset_pkg::cmd_t   c;
  assign c   = (state == sset_pkg::S_IDLE) ? cmd : cur;
  assign a_s = c.sel;
  assign b_s = ~c.sel;
  assign na  = size[a_s];
  assign nb  = size[b_s];

  assign out_free = !res_valid || res_ready;

  // element under the scan pointer: left set first, then right
  always_comb begin
    elem = (state == sset_pkg::S_RIGHT) ? ent[b_s][idx[IW-1:0]] : ent[a_s][idx[IW-1:0]];
  end

  always_comb begin
    for (int i = 0; i < D; i++) begin
      hit_a[i] = (CW'(i) < na) && (ent[a_s][i] == c.value);
      hit_b[i] = (CW'(i) < ((state == sset_pkg::S_RIGHT) ? na : nb)) &&
                 (ent[(state == sset_pkg::S_RIGHT) ? a_s : b_s][i] == elem);
    end
    v_in_a = |hit_a;
    hit_pos = '0;
    for (int i = D - 1; i >= 0; i--) begin
      if (hit_a[i]) hit_pos = IW'(i);
    end
    elem_in_other = |hit_b;
  end

  assign scan_done = (state == sset_pkg::S_RIGHT) ? (idx >= nb) : (idx >= na);

  always_comb begin
    unique case (cur.op)
      sset_pkg::OP_INTER: want = (state == sset_pkg::S_RIGHT) && elem_in_other;
      sset_pkg::OP_UNION: want = (state == sset_pkg::S_LEFT) || !elem_in_other;
      default:            want = !elem_in_other;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      sset_pkg::S_IDLE: begin
        if (cmd_valid && out_free && cmd.op >= sset_pkg::OP_INTER) begin
          state_next = sset_pkg::S_LEFT;
        end
      end
      sset_pkg::S_LEFT: begin
        if (out_free && scan_done) begin
          if (cur.op == sset_pkg::OP_DIFF) state_next = sset_pkg::S_TAIL;
          else state_next = sset_pkg::S_RIGHT;
        end
      end
      sset_pkg::S_RIGHT: begin
        if (out_free && scan_done) state_next = sset_pkg::S_TAIL;
      end
      sset_pkg::S_TAIL: begin
        if (out_free) state_next = sset_pkg::S_IDLE;
      end
      default: state_next = sset_pkg::S_IDLE;
    endcase
  end

  assign cmd_ready = (state == sset_pkg::S_IDLE) && out_free;

  // a pending member is held back until the next one is found, so the final one can carry last
  logic        pend;
  logic [31:0] pend_val;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sset_pkg::S_IDLE;
      size[0]   <= '0;
      size[1]   <= '0;
      res_valid <= 1'b0;
      pend      <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (res_valid && res_ready) res_valid <= 1'b0;
      unique case (state)
        sset_pkg::S_IDLE: begin
          if (cmd_valid && out_free) begin
            cur     <= cmd;
            idx     <= '0;
            pend    <= 1'b0;
            if (cmd.op < sset_pkg::OP_INTER) begin
              res_valid      <= 1'b1;
              res.member     <= '0;
              res.has_member <= 1'b0;
              res.last       <= 1'b1;
              unique case (cmd.op)
                sset_pkg::OP_INSERT: begin
                  if (v_in_a) begin
                    res.status <= sset_pkg::ST_MISS;
                    res.set_count <= 5'(na);
                  end else if (na >= CW'(D)) begin
                    res.status <= sset_pkg::ST_FULL;
                    res.set_count <= 5'(na);
                  end else begin
                    ent[a_s][na[IW-1:0]] <= cmd.value;
                    size[a_s] <= na + 1'b1;
                    res.status <= sset_pkg::ST_OK;
                    res.set_count <= 5'(na + 1'b1);
                  end
                end
                sset_pkg::OP_REMOVE: begin
                  if (v_in_a) begin
                    for (int i = 0; i < D - 1; i++) begin
                      if (IW'(i) >= hit_pos) ent[a_s][i] <= ent[a_s][i+1];
                    end
                    size[a_s] <= na - 1'b1;
                    res.status <= sset_pkg::ST_OK;
                    res.set_count <= 5'(na - 1'b1);
                  end else begin
                    res.status <= sset_pkg::ST_MISS;
                    res.set_count <= 5'(na);
                  end
                end
                sset_pkg::OP_LOOKUP: begin
                  res.status <= v_in_a ? sset_pkg::ST_OK : sset_pkg::ST_MISS;
                  res.set_count <= 5'(na);
                end
                default: begin
                  size[a_s] <= '0;
                  res.status <= sset_pkg::ST_OK;
                  res.set_count <= '0;
                end
              endcase
            end
          end
        end
        sset_pkg::S_LEFT, sset_pkg::S_RIGHT: begin
          if (out_free) begin
            if (scan_done) begin
              idx <= '0;
            end else begin
              idx <= idx + 1'b1;
              if (!(state == sset_pkg::S_LEFT && cur.op == sset_pkg::OP_INTER) && want) begin
                pend     <= 1'b1;
                pend_val <= elem;
                if (pend) begin
                  res_valid      <= 1'b1;
                  res.status     <= sset_pkg::ST_OK;
                  res.member     <= pend_val;
                  res.has_member <= 1'b1;
                  res.last       <= 1'b0;
                  res.set_count  <= 5'(na);
                end
              end
            end
          end
        end
        default: begin
          if (out_free) begin
            res_valid      <= 1'b1;
            res.status     <= sset_pkg::ST_OK;
            res.member     <= pend ? pend_val : '0;
            res.has_member <= pend;
            res.last       <= 1'b1;
            res.set_count  <= 5'(na);
          end
        end
      endcase
    end
  end

endmodule

// ===== rtl/small_set_store_with_set_ops_unit.sv =====
// ----------------------------------------------------------------------------
// small_set_store_with_set_ops_unit
// two insertion-ordered sets of 32-bit members with table and set operations
// ----------------------------------------------------------------------------
// s_axis carries one command per beat; m_axis returns result beats.
// s_axis_tdata: opcode[2:0], set_select[3], value[35:4], zero pad to 40 bits.
// m_axis_tdata: status[1:0], member[33:2], has_member[34], set_count[39:35].
// m_axis_tlast marks the final result beat of a command.
// A two-entry command queue separates the input stage from the executor.
// Insert, remove, lookup and clear are handled in the executor's idle
// state and return one beat from its result register; one such command
// per cycle when the output is taken.
// Set operations scan the left set, then the right set (difference scans
// only the left), one element per cycle while the output is free,
// comparing it against all entries of the other set in parallel; one
// member beat per cycle at most.
// Reset empties both sets and drops queued commands. When m_axis stalls the
// executor holds its result register and the queue fills, then s_axis_tready
// goes low.
module small_set_store_with_set_ops_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // opcode, set_select, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // status, member, has_member, set_count
  output logic        m_axis_tlast
);

  logic           cmd_valid;
  logic           cmd_ready;
  sset_pkg::cmd_t cmd;
  sset_pkg::res_t res;

  sset_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  sset_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {res.set_count, res.has_member, res.member, res.status};
  assign m_axis_tlast = res.last;

endmodule

// ===== rtl/sset_checker.sv =====
// ----------------------------------------------------------------------------
// sset_checker
// port-level checks on the result stream
// ----------------------------------------------------------------------------
module sset_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // a held result beat does not change
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

  // no member without has_member
  a_member: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[34] |-> m_axis_tdata[33:2] == 32'd0)
    else $error("member without flag");

  // a beat without a member closes its command
  a_lastnm: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[34] |-> m_axis_tlast)
    else $error("non-member beat not last");

  // count never exceeds depth
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:35] <= 5'd16)
    else $error("count out of range");

endmodule

bind small_set_store_with_set_ops_unit sset_checker u_sset_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
